// ===== hdl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared codes, palette stop tables and pipeline side-band type for the
// point colouring block.
// ----------------------------------------------------------------------------
package psc_pkg;

  // colour mode codes
  localparam logic [3:0] MODE_RGB       = 4'd0;
  localparam logic [3:0] MODE_ELEVATION = 4'd1;
  localparam logic [3:0] MODE_X         = 4'd2;
  localparam logic [3:0] MODE_WHITE     = 4'd3;
  localparam logic [3:0] MODE_RAINBOW   = 4'd4;
  localparam logic [3:0] MODE_TURBO     = 4'd5;
  localparam logic [3:0] MODE_VIRIDIS   = 4'd6;
  localparam logic [3:0] MODE_HEAT      = 4'd7;
  localparam logic [3:0] MODE_GRAY      = 4'd8;

  // palette codes
  localparam logic [2:0] PAL_RAINBOW = 3'd0;
  localparam logic [2:0] PAL_TURBO   = 3'd1;
  localparam logic [2:0] PAL_VIRIDIS = 3'd2;
  localparam logic [2:0] PAL_HEAT    = 3'd3;
  localparam logic [2:0] PAL_GRAY    = 3'd4;

  // register indexes
  localparam logic [2:0] REG_COLOR_MODE      = 3'd0;
  localparam logic [2:0] REG_DEFAULT_PALETTE = 3'd1;
  localparam logic [2:0] REG_Z_MINIMUM       = 3'd2;
  localparam logic [2:0] REG_Z_MAXIMUM       = 3'd3;
  localparam logic [2:0] REG_X_MINIMUM       = 3'd4;
  localparam logic [2:0] REG_X_MAXIMUM       = 3'd5;

  localparam logic [7:0] VIRIDIS_STOPS [5][3] = '{
    '{8'd68, 8'd1, 8'd84}, '{8'd59, 8'd82, 8'd139}, '{8'd33, 8'd145, 8'd140},
    '{8'd94, 8'd201, 8'd98}, '{8'd253, 8'd231, 8'd37}};
  localparam logic [7:0] TURBO_STOPS [5][3] = '{
    '{8'd48, 8'd18, 8'd59}, '{8'd50, 8'd101, 8'd255}, '{8'd45, 8'd200, 8'd130},
    '{8'd245, 8'd210, 8'd70}, '{8'd180, 8'd4, 8'd38}};

  // side-band that travels with each point through the divider
  typedef struct packed {
    logic       pass;  // colour is final, no palette lookup
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] pal;
  } psc_side_t;

  function automatic logic [7:0] stop_val(input logic turbo, input logic [2:0] idx,
                                          input logic [1:0] ch);
    logic [7:0] val;
    if (turbo) val = TURBO_STOPS[idx][ch];
    else       val = VIRIDIS_STOPS[idx][ch];
    return val;
  endfunction

endpackage

// ===== hdl/psc_div.sv =====
// ----------------------------------------------------------------------------
// psc_div
// Pipelined normaliser: u = clamp(d / r) with FRAC_BITS fraction bits, one
// quotient bit per stage, restoring division.
// ----------------------------------------------------------------------------
module psc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [32:0]  diff,
  input  logic signed [32:0]  range_w,
  input  psc_pkg::psc_side_t  in_side,
  output logic                out_valid,
  output logic [FRAC_BITS:0]  norm,
  output psc_pkg::psc_side_t  out_side
);
  import psc_pkg::*;

  localparam int F = FRAC_BITS;

  logic             valid [0:F];
  logic [32:0]      rem   [0:F];
  logic [32:0]      den   [0:F];
  logic [F-1:0]     quo   [0:F];
  logic             zero  [0:F];
  logic             one   [0:F];
  psc_side_t        side  [0:F];

  // stage 0: classify the operands
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
    rem[0]  <= diff;
    den[0]  <= range_w;
    quo[0]  <= '0;
    zero[0] <= (range_w <= 33'sd0) || (diff <= 33'sd0);
    one[0]  <= (diff >= range_w);
    side[0] <= in_side;
  end

  // stages 1..F: one quotient bit each
  for (genvar j = 0; j < F; j++) begin : g_stage
    logic [32:0] rem2;
    logic        ge;
    assign rem2 = {rem[j][31:0], 1'b0};
    assign ge   = rem[j][32] || (rem2 >= den[j]);
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else begin
        valid[j+1] <= valid[j];
      end
      rem[j+1]  <= ge ? (rem2 - den[j]) : rem2;
      den[j+1]  <= den[j];
      quo[j+1]  <= {quo[j][F-2:0], ge};
      zero[j+1] <= zero[j];
      one[j+1]  <= one[j];
      side[j+1] <= side[j];
    end
  end

  assign out_valid = valid[F];
  assign out_side  = side[F];
  assign norm      = zero[F] ? '0 : (one[F] ? {1'b1, {F{1'b0}}} : {1'b0, quo[F]});

endmodule

// ===== hdl/psc_map.sv =====
// ----------------------------------------------------------------------------
// psc_map
// Palette lookup: per channel base + ((k * coef + round) >>> FRAC_BITS), in
// three stages (operand select, multiply, combine).
// ----------------------------------------------------------------------------
module psc_map #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [FRAC_BITS:0]  norm,
  input  psc_pkg::psc_side_t  in_side,
  output logic                out_valid,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);
  import psc_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int PW    = F + 13;
  localparam int ONE_I = 1 << F;
  localparam int K35_I = ((35 << F) + 50) / 100;
  localparam logic [F:0] ONE  = (F+1)'(ONE_I);
  localparam logic [F:0] QTR  = (F+1)'(ONE_I / 4);
  localparam logic [F:0] HALF = (F+1)'(ONE_I / 2);
  localparam logic [F:0] TQ   = (F+1)'(3 * ONE_I / 4);
  localparam logic [F:0] K35  = (F+1)'(K35_I);
  localparam logic signed [10:0] C1020 = 11'sd1020;
  localparam logic signed [10:0] C255  = 11'sd255;
  localparam logic signed [PW-1:0] RND = PW'(ONE_I / 2);

  logic [7:0]           base_c [3];
  logic signed [10:0]   coef_c [3];
  logic [F:0]           k_c    [3];
  logic                 rnd_c;

  logic [F+2:0] s4;
  logic [1:0]   seg;
  logic [F:0]   tfrac;
  logic [F:0]   hd;

  // select operands per palette
  always_comb begin
    s4    = {norm, 2'b00};
    seg   = s4[F+2] ? 2'd3 : s4[F+1:F];
    tfrac = s4[F+2] ? ONE : {1'b0, s4[F-1:0]};
    hd    = norm - K35;
    rnd_c = 1'b0;
    for (int c = 0; c < 3; c++) begin
      base_c[c] = 8'd0;
      coef_c[c] = 11'sd0;
      k_c[c]    = '0;
    end
    if (in_side.pass) begin
      base_c[0] = in_side.red;
      base_c[1] = in_side.green;
      base_c[2] = in_side.blue;
    end else begin
      case (in_side.pal)
        PAL_TURBO, PAL_VIRIDIS: begin
          for (int c = 0; c < 3; c++) begin
            base_c[c] = stop_val(in_side.pal == PAL_TURBO, {1'b0, seg}, 2'(c));
            coef_c[c] = 11'($signed({3'b0, stop_val(in_side.pal == PAL_TURBO,
                                                     3'({1'b0, seg} + 3'd1), 2'(c))}))
                      - 11'($signed({3'b0, base_c[c]}));
            k_c[c]    = tfrac;
          end
        end
        PAL_HEAT: begin
          rnd_c     = 1'b1;
          coef_c[0] = C255;
          coef_c[1] = C255;
          coef_c[2] = C255;
          k_c[0]    = (norm >= HALF) ? ONE : {norm[F-1:0], 1'b0};
          k_c[1]    = (norm <= K35) ? '0 : ((hd >= HALF) ? ONE : {hd[F-1:0], 1'b0});
          k_c[2]    = (norm <= TQ) ? '0 : 2'(0) + {norm[F-2:0] - TQ[F-2:0], 2'b00};
        end
        PAL_GRAY: begin
          rnd_c = 1'b1;
          for (int c = 0; c < 3; c++) begin
            coef_c[c] = C255;
            k_c[c]    = norm;
          end
        end
        default: begin
          if (norm < QTR) begin
            base_c[0] = 8'd255;
            coef_c[1] = C1020;
            k_c[1]    = norm;
          end else if (norm < HALF) begin
            coef_c[0] = C1020;
            k_c[0]    = HALF - norm;
            base_c[1] = 8'd255;
          end else if (norm < TQ) begin
            base_c[1] = 8'd255;
            coef_c[2] = C1020;
            k_c[2]    = norm - HALF;
          end else begin
            coef_c[1] = C1020;
            k_c[1]    = ONE - norm;
            base_c[2] = 8'd255;
          end
        end
      endcase
    end
  end

  logic                 v1, v2, v3;
  logic [7:0]           base1 [3];
  logic signed [10:0]   coef1 [3];
  logic [F:0]           k1    [3];
  logic                 rnd1;
  logic [7:0]           base2 [3];
  logic signed [PW-1:0] prod2 [3];
  logic [7:0]           col3  [3];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // operand, product and colour registers
  always_ff @(posedge clk) begin
    rnd1 <= rnd_c;
    for (int c = 0; c < 3; c++) begin
      base1[c] <= base_c[c];
      coef1[c] <= coef_c[c];
      k1[c]    <= k_c[c];
      base2[c] <= base1[c];
      prod2[c] <= PW'($signed({1'b0, k1[c]})) * PW'(coef1[c]) + (rnd1 ? RND : '0);
      col3[c]  <= base2[c] + 8'(prod2[c] >>> F);
    end
  end

  assign out_valid = v3;
  assign red       = col3[0];
  assign green     = col3[1];
  assign blue      = col3[2];

endmodule

// ===== hdl/point_scalar_colormap.sv =====
// ----------------------------------------------------------------------------
// point_scalar_colormap
// Pipeline from start to done: one input register, one classify stage,
// FRAC_BITS divider stages, three palette stages.
// Throughput: one point per cycle; busy is always low, the pipeline never stalls.
// Reset: rst clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module point_scalar_colormap #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_z,
  input  logic               own_color,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import psc_pkg::*;

  logic [3:0]         color_mode;
  logic [2:0]         default_palette;
  logic signed [31:0] z_minimum, z_maximum, x_minimum, x_maximum;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode      <= '0;
      default_palette <= '0;
      z_minimum       <= '0;
      z_maximum       <= '0;
      x_minimum       <= '0;
      x_maximum       <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_COLOR_MODE:      color_mode      <= pwdata[3:0];
        REG_DEFAULT_PALETTE: default_palette <= pwdata[2:0];
        REG_Z_MINIMUM:       z_minimum       <= pwdata;
        REG_Z_MAXIMUM:       z_maximum       <= pwdata;
        REG_X_MINIMUM:       x_minimum       <= pwdata;
        REG_X_MAXIMUM:       x_maximum       <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:2])
      REG_COLOR_MODE:      prdata = {28'd0, color_mode};
      REG_DEFAULT_PALETTE: prdata = {29'd0, default_palette};
      REG_Z_MINIMUM:       prdata = z_minimum;
      REG_Z_MAXIMUM:       prdata = z_maximum;
      REG_X_MINIMUM:       prdata = x_minimum;
      REG_X_MAXIMUM:       prdata = x_maximum;
      default:             prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // decode mode and form the normaliser operands
  psc_side_t          side_c;
  logic               use_x;
  logic signed [32:0] diff_c, range_c;

  always_comb begin
    use_x       = (color_mode == MODE_X);
    side_c.pass = 1'b0;
    side_c.red  = in_red;
    side_c.green = in_green;
    side_c.blue = in_blue;
    side_c.pal  = default_palette;
    if (color_mode == MODE_RGB && own_color) begin
      side_c.pass = 1'b1;
    end else if (color_mode == MODE_WHITE) begin
      side_c.pass  = 1'b1;
      side_c.red   = 8'd255;
      side_c.green = 8'd255;
      side_c.blue  = 8'd255;
    end else if (use_x) begin
      side_c.pal = PAL_RAINBOW;
    end else if (color_mode inside {[MODE_RAINBOW:MODE_GRAY]}) begin
      side_c.pal = 3'(color_mode - MODE_RAINBOW);
    end
    if (side_c.pal > PAL_GRAY) side_c.pal = PAL_RAINBOW;
    if (use_x) begin
      diff_c  = 33'(coord_x) - 33'(x_minimum);
      range_c = 33'(x_maximum) - 33'(x_minimum);
    end else begin
      diff_c  = 33'(coord_z) - 33'(z_minimum);
      range_c = 33'(z_maximum) - 33'(z_minimum);
    end
  end

  logic               v0;
  logic signed [32:0] diff0, range0;
  psc_side_t          side0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    diff0  <= diff_c;
    range0 <= range_c;
    side0  <= side_c;
  end

  logic             dv;
  logic [FRAC_BITS:0] norm;
  psc_side_t        dside;

  psc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .diff      (diff0),
    .range_w   (range0),
    .in_side   (side0),
    .out_valid (dv),
    .norm      (norm),
    .out_side  (dside)
  );

  psc_map #(.FRAC_BITS(FRAC_BITS)) u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv),
    .norm      (norm),
    .in_side   (dside),
    .out_valid (done),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

endmodule

// ===== sim/tb_point_scalar_colormap.sv =====
// ----------------------------------------------------------------------------
// tb_point_scalar_colormap
// Self-checking bench for the point colouring block: drives points through the
// command port, programs the registers over APB between phases, predicts every
// colour in a small scoreboard and compares each done strobe field by field.
// ----------------------------------------------------------------------------
module tb_point_scalar_colormap;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  localparam longint UNIT = 64'sd65536;
  localparam longint K35  = ((64'sd35 <<< 16) + 64'sd50) / 64'sd100;
  localparam int LATENCY  = 21;
  localparam int LIMIT    = 400000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic               own;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } point_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  // scoreboard: register shadow, colour predictor and queue of pending colours
  class colour_board;
    logic [3:0]         mode;
    logic [2:0]         pal;
    logic signed [31:0] zlo, zhi, xlo, xhi;
    colour_t            pending[$];
    int                 errors;

    function void clear();
      mode = MODE_RGB; pal = PAL_RAINBOW;
      zlo = 0; zhi = 0; xlo = 0; xhi = 0;
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_COLOR_MODE:      mode = val[3:0];
        REG_DEFAULT_PALETTE: pal  = val[2:0];
        REG_Z_MINIMUM:       zlo  = val;
        REG_Z_MAXIMUM:       zhi  = val;
        REG_X_MINIMUM:       xlo  = val;
        REG_X_MAXIMUM:       xhi  = val;
        default: ;
      endcase
    endfunction

    function longint scale(longint v, longint lo, longint hi);
      longint span, d;
      span = hi - lo;
      d = v - lo;
      if (span <= 0 || d <= 0) return 0;
      if (d >= span) return UNIT;
      return (d <<< 16) / span;
    endfunction

    function logic [7:0] ramp(longint k);
      return 8'((k * 1020) >>> 16);
    endfunction

    function logic [7:0] round_to_byte(longint k);
      return 8'((k * 255 + UNIT / 2) >>> 16);
    endfunction

    function longint sat(longint k);
      if (k < 0) return 0;
      if (k > UNIT) return UNIT;
      return k;
    endfunction

    function colour_t shade(point_t p);
      colour_t c;
      logic [2:0] sel;
      longint u, s, seg, t, a, b, tot;
      logic [7:0] ch[3];
      c = '0;
      sel = pal;
      if (mode == MODE_RGB && p.own) return {p.red, p.green, p.blue};
      if (mode == MODE_WHITE) return {8'd255, 8'd255, 8'd255};
      if (mode == MODE_X) begin
        u = scale(p.x, xlo, xhi);
        sel = PAL_RAINBOW;
      end else begin
        u = scale(p.z, zlo, zhi);
        if (mode >= MODE_RAINBOW && mode <= MODE_GRAY) sel = 3'(mode - MODE_RAINBOW);
      end
      if (sel > PAL_GRAY) sel = PAL_RAINBOW;
      case (sel)
        PAL_TURBO, PAL_VIRIDIS: begin
          s = u * 4;
          seg = s >>> 16;
          if (seg > 3) seg = 3;
          t = s - (seg <<< 16);
          for (int k = 0; k < 3; k++) begin
            a = (sel == PAL_TURBO) ? TURBO_STOPS[seg][k] : VIRIDIS_STOPS[seg][k];
            b = (sel == PAL_TURBO) ? TURBO_STOPS[seg+1][k] : VIRIDIS_STOPS[seg+1][k];
            tot = a * UNIT + (b - a) * t;
            if (tot < 0) tot = 0;
            ch[k] = 8'(tot >>> 16);
          end
          c = {ch[0], ch[1], ch[2]};
        end
        PAL_HEAT: c = {round_to_byte(sat(2 * u)), round_to_byte(sat(2 * (u - K35))),
                       round_to_byte(sat(4 * (u - 3 * UNIT / 4)))};
        PAL_GRAY: c = {3{round_to_byte(u)}};
        default: begin
          if (u < UNIT / 4)          c = {8'd255, ramp(u), 8'd0};
          else if (u < UNIT / 2)     c = {ramp(UNIT / 2 - u), 8'd255, 8'd0};
          else if (u < 3 * UNIT / 4) c = {8'd0, 8'd255, ramp(u - UNIT / 2)};
          else                       c = {8'd0, ramp(UNIT - u), 8'd255};
        end
      endcase
      return c;
    endfunction

    function void note_point(point_t p);
      pending.push_back(shade(p));
    endfunction

    function void check_colour(colour_t got);
      colour_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected colour %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        errors++;
        if (errors <= 10) $display("colour mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  point_t pt = '0;
  logic [7:0] out_red, out_green, out_blue;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  colour_board board;
  int cycles = 0;

  always #2 clk = ~clk;

  point_scalar_colormap dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .coord_x(pt.x), .coord_z(pt.z), .own_color(pt.own),
    .in_red(pt.red), .in_green(pt.green), .in_blue(pt.blue),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // note accepted transactions and check every strobed colour
  always @(posedge clk) begin
    if (!rst && start && !busy) board.note_point(pt);
    if (!rst && done) board.check_colour({out_red, out_green, out_blue});
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.write_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait for the pipeline to drain before touching the registers
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic setup(logic [3:0] mode, logic [2:0] pal, logic [31:0] zlo,
                       logic [31:0] zhi, logic [31:0] xlo, logic [31:0] xhi);
    drain();
    reg_write(REG_COLOR_MODE, {$urandom} & 32'hFFFF_FFF0 | mode);
    reg_write(REG_DEFAULT_PALETTE, {$urandom} & 32'hFFFF_FFF8 | pal);
    reg_write(REG_Z_MINIMUM, zlo);
    reg_write(REG_Z_MAXIMUM, zhi);
    reg_write(REG_X_MINIMUM, xlo);
    reg_write(REG_X_MAXIMUM, xhi);
  endtask

  // present one point and hold it until accepted, with an optional gap first
  task automatic send_point(point_t p, bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    pt <= p;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] coord_near(logic signed [31:0] lo, logic signed [31:0] hi);
    longint span;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return lo;
      2: return hi;
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: begin
        span = longint'(hi) - longint'(lo);
        if (span <= 0) return $urandom;
        return 32'(longint'(lo) - span / 8 + ((longint'($urandom) << 16) %
                   (span + span / 4 + 1)));
      end
    endcase
  endfunction

  function automatic point_t rand_point(logic signed [31:0] lo, logic signed [31:0] hi);
    point_t p;
    p.x = coord_near(lo, hi);
    p.z = coord_near(lo, hi);
    p.own = 1'($urandom_range(0, 1));
    p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
    return p;
  endfunction

  initial begin
    point_t p;
    logic signed [31:0] lo, hi;
    logic [3:0] dir_modes[10] = '{MODE_RGB, MODE_ELEVATION, MODE_X, MODE_WHITE, MODE_RAINBOW,
                                  MODE_TURBO, MODE_VIRIDIS, MODE_HEAT, MODE_GRAY, 4'd12};
    longint quarter[6] = '{-1, 0, UNIT, 2 * UNIT, 3 * UNIT, 4 * UNIT};
    int sent;
    board = new();
    board.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: every mode, quarter boundaries, range ends, own colour both ways
    foreach (dir_modes[m]) begin
      setup(dir_modes[m], (m == 9) ? 3'd6 : 3'(m % 5), 0, 32'(4 * UNIT), 0, 32'(4 * UNIT));
      for (int k = 0; k < 3; k++) begin
        p.x = 32'(quarter[(m + 2 * k) % 6]);
        p.z = 32'(quarter[(m + 2 * k + 1) % 6]);
        p.own = k[0];
        p.red = 8'hFF; p.green = 8'h00; p.blue = 8'hA5;
        send_point(p, 1'b0);
      end
    end

    // inverted and full ranges
    setup(MODE_ELEVATION, PAL_GRAY, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_point('{x: 32'h8000_0000, z: 32'h7FFF_FFFF, own: 1'b1,
                 red: 8'd0, green: 8'd0, blue: 8'd0}, 1'b0);
    setup(MODE_GRAY, PAL_GRAY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point('{x: 32'h7FFF_FFFF, z: 32'h0000_0000, own: 1'b0,
                 red: 8'd1, green: 8'd2, blue: 8'd3}, 1'b0);
    send_point('{x: 32'h0, z: 32'h7FFF_FFFF, own: 1'b0,
                 red: 8'd1, green: 8'd2, blue: 8'd3}, 1'b0);

    // random phases, each under a fresh register setting
    sent = 0;
    while (sent < 1550) begin
      case ($urandom_range(0, 4))
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin lo = $urandom; hi = lo; end
        2: begin lo = $urandom; hi = $urandom; end
        default: begin
          lo = $signed(32'($urandom_range(0, 'hFFFF))) - 32'sh8000 <<< 8;
          hi = lo + 32'($urandom_range(1, 'hFFFFF));
        end
      endcase
      setup(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), lo, hi,
            $urandom_range(0, 3) == 0 ? 32'($urandom) : lo,
            $urandom_range(0, 3) == 0 ? 32'($urandom) : hi);
      repeat ($urandom_range(40, 120)) begin
        send_point(rand_point(lo, hi), sent < 1300 && sent % 200 < 150);
        sent++;
      end
    end

    drain();
    if (board.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
